>>> rtl/spp_pkg.sv
// Package: payload structs, widths and internal pipeline types for segment point projection.
`default_nettype none

package spp_pkg;

    localparam int COORD_BITS = 16;
    localparam int FRAC_BITS  = 16;

    // Difference, product and dot-product widths, all exact.
    localparam int DIFF_BITS = COORD_BITS + 1;
    localparam int PROD_BITS = 2 * DIFF_BITS;
    localparam int DOT_BITS  = PROD_BITS + 1;

    typedef struct packed {
        logic                         func;
        logic signed [COORD_BITS-1:0] ax;
        logic signed [COORD_BITS-1:0] ay;
        logic signed [COORD_BITS-1:0] bx;
        logic signed [COORD_BITS-1:0] by;
        logic signed [COORD_BITS-1:0] px;
        logic signed [COORD_BITS-1:0] py;
    } query_t;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] rx;
        logic signed [COORD_BITS-1:0] ry;
        logic                         defined;
    } result_t;

    // Which result an item takes once s and q are known.
    typedef enum logic [1:0] {
        SEL_NONE = 2'd0,
        SEL_A    = 2'd1,
        SEL_B    = 2'd2,
        SEL_MID  = 2'd3
    } sel_t;

    // Side data that rides along with every item through the pipeline.
    typedef struct packed {
        logic                         func;
        sel_t                         sel;
        logic signed [COORD_BITS-1:0] ax;
        logic signed [COORD_BITS-1:0] ay;
        logic signed [DIFF_BITS-1:0]  ux;
        logic signed [DIFF_BITS-1:0]  uy;
    } carry_t;

endpackage

`default_nettype wire

>>> rtl/segment_point_projection_unit.sv
// Top level: pipelined projection of a point onto a segment, strict or clamped.
//
// Usage: one query beat on query/query_valid/query_ready carries the segment
// endpoints A and B, the point P and the mode bit func. One result beat on
// result/result_valid/result_ready returns the point and the defined flag.
// Results leave in the order the queries arrived, one per query.
//
// Throughput is one beat per cycle while the receiver keeps up: the quotient
// t = floor(s * 2^F / q) comes from a restoring divider laid out as FRAC_BITS
// stages, one quotient bit per stage, behind four stages that form u, w, the
// dot products and the classification.
//
// Reset clears every valid bit; no payload register is reset.
// When the receiver stalls, the result register holds and one more beat is
// caught in a skid register; the pipeline then freezes in place, with every
// item and its valid bit kept, until the result is taken.
`default_nettype none

module segment_point_projection_unit #(
    parameter int FRAC_BITS = spp_pkg::FRAC_BITS
) (
    input  wire                clk,
    input  wire                rst_n,
    input  wire                query_valid,
    output logic               query_ready,
    input  wire spp_pkg::query_t query,
    output logic               result_valid,
    input  wire                result_ready,
    output spp_pkg::result_t   result
);
    import spp_pkg::*;

    localparam int C  = COORD_BITS;
    localparam int DW = DIFF_BITS;
    localparam int MW = PROD_BITS;
    localparam int SW = DOT_BITS;
    localparam int PW = DW + FRAC_BITS + 1;

    logic en;
    logic load_out;

    // Stage 1: u = B - A, w = P - A.
    logic                 s1_vld_reg;
    carry_t               s1_reg;
    logic signed [DW-1:0] s1_wx_reg;
    logic signed [DW-1:0] s1_wy_reg;

    // Stage 2: the four exact products.
    logic                 s2_vld_reg;
    carry_t               s2_reg;
    logic signed [MW-1:0] s2_uwx_reg;
    logic signed [MW-1:0] s2_uwy_reg;
    logic signed [MW-1:0] s2_uux_reg;
    logic signed [MW-1:0] s2_uuy_reg;

    // Stage 3: s = u.w and q = u.u.
    logic                 s3_vld_reg;
    carry_t               s3_reg;
    logic signed [SW-1:0] s3_s_reg;
    logic signed [SW-1:0] s3_q_reg;

    // Stage 4: classification and divider operands.
    logic                 s4_vld_reg;
    carry_t               s4_reg;
    logic [SW-1:0]        s4_r_reg;
    logic [SW-1:0]        s4_q_reg;
    sel_t                 sel_next;

    // Divider stages, one quotient bit each.
    logic                 dv_vld_reg [FRAC_BITS];
    carry_t               dv_reg     [FRAC_BITS];
    logic [SW-1:0]        dv_r_reg   [FRAC_BITS];
    logic [SW-1:0]        dv_q_reg   [FRAC_BITS];
    logic [FRAC_BITS-1:0] dv_t_reg   [FRAC_BITS];

    // Multiply stage: u * t per axis.
    logic                 m_vld_reg;
    carry_t               m_reg;
    logic signed [PW-1:0] m_px_reg;
    logic signed [PW-1:0] m_py_reg;

    // Output and skid registers.
    logic                 result_valid_reg;
    result_t              result_reg;
    logic                 skid_valid_reg;
    result_t              skid_reg;
    result_t              res_next;

    logic signed [PW-1:0] shx;
    logic signed [PW-1:0] shy;

    // The pipeline moves only while the skid register is empty.
    assign en          = !skid_valid_reg;
    assign load_out    = !result_valid_reg || result_ready;
    assign query_ready = en;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // ---------------- Stage 1 ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_vld_reg <= query_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_reg.func <= query.func;
            s1_reg.sel  <= SEL_NONE;
            s1_reg.ax   <= query.ax;
            s1_reg.ay   <= query.ay;
            s1_reg.ux   <= DW'(query.bx) - DW'(query.ax);
            s1_reg.uy   <= DW'(query.by) - DW'(query.ay);
            s1_wx_reg   <= DW'(query.px) - DW'(query.ax);
            s1_wy_reg   <= DW'(query.py) - DW'(query.ay);
        end
    end

    // ---------------- Stage 2 ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            s2_vld_reg <= s1_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_reg     <= s1_reg;
            s2_uwx_reg <= MW'(s1_reg.ux) * MW'(s1_wx_reg);
            s2_uwy_reg <= MW'(s1_reg.uy) * MW'(s1_wy_reg);
            s2_uux_reg <= MW'(s1_reg.ux) * MW'(s1_reg.ux);
            s2_uuy_reg <= MW'(s1_reg.uy) * MW'(s1_reg.uy);
        end
    end

    // ---------------- Stage 3 ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            s3_vld_reg <= s2_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s3_reg   <= s2_reg;
            s3_s_reg <= SW'(s2_uwx_reg) + SW'(s2_uwy_reg);
            s3_q_reg <= SW'(s2_uux_reg) + SW'(s2_uuy_reg);
        end
    end

    // ---------------- Stage 4 ----------------
    always_comb
    begin
        if (!s3_reg.func && (s3_s_reg < 0 || s3_s_reg > s3_q_reg))
        begin
            sel_next = SEL_NONE;
        end
        else if (s3_s_reg <= 0)
        begin
            sel_next = SEL_A;
        end
        else if (s3_s_reg >= s3_q_reg)
        begin
            sel_next = SEL_B;
        end
        else
        begin
            sel_next = SEL_MID;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s4_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            s4_vld_reg <= s3_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s4_reg.func <= s3_reg.func;
            s4_reg.sel  <= sel_next;
            s4_reg.ax   <= s3_reg.ax;
            s4_reg.ay   <= s3_reg.ay;
            s4_reg.ux   <= s3_reg.ux;
            s4_reg.uy   <= s3_reg.uy;
            s4_r_reg    <= s3_s_reg;
            s4_q_reg    <= s3_q_reg;
        end
    end

    // ---------------- Divider ----------------
    // Restoring division: the partial remainder stays below q, so doubling
    // it needs only one extra bit.
    for (genvar k = 0; k < FRAC_BITS; k++)
    begin : g_div
        logic                 v_in;
        carry_t               c_in;
        logic [SW-1:0]        r_in;
        logic [SW-1:0]        q_in;
        logic [FRAC_BITS-1:0] t_in;
        logic [SW:0]          r2;
        logic                 ge;

        if (k == 0)
        begin : g_first
            assign v_in = s4_vld_reg;
            assign c_in = s4_reg;
            assign r_in = s4_r_reg;
            assign q_in = s4_q_reg;
            assign t_in = '0;
        end
        else
        begin : g_rest
            assign v_in = dv_vld_reg[k-1];
            assign c_in = dv_reg[k-1];
            assign r_in = dv_r_reg[k-1];
            assign q_in = dv_q_reg[k-1];
            assign t_in = dv_t_reg[k-1];
        end

        assign r2 = {r_in, 1'b0};
        assign ge = (r2 >= {1'b0, q_in});

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_vld_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                dv_vld_reg[k] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dv_reg[k]   <= c_in;
                dv_q_reg[k] <= q_in;
                dv_r_reg[k] <= ge ? SW'(r2 - {1'b0, q_in}) : SW'(r2);
                dv_t_reg[k] <= {t_in[FRAC_BITS-2:0], ge};
            end
        end
    end

    // ---------------- Multiply ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            m_vld_reg <= dv_vld_reg[FRAC_BITS-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_reg    <= dv_reg[FRAC_BITS-1];
            m_px_reg <= PW'(dv_reg[FRAC_BITS-1].ux)
                        * $signed({1'b0, dv_t_reg[FRAC_BITS-1]});
            m_py_reg <= PW'(dv_reg[FRAC_BITS-1].uy)
                        * $signed({1'b0, dv_t_reg[FRAC_BITS-1]});
        end
    end

    // ---------------- Result select ----------------
    // An arithmetic shift gives the floor of the signed offset directly.
    assign shx = m_px_reg >>> FRAC_BITS;
    assign shy = m_py_reg >>> FRAC_BITS;

    always_comb
    begin
        res_next.defined = 1'b1;
        case (m_reg.sel)
            SEL_NONE:
            begin
                res_next.rx      = '0;
                res_next.ry      = '0;
                res_next.defined = 1'b0;
            end
            SEL_A:
            begin
                res_next.rx = m_reg.ax;
                res_next.ry = m_reg.ay;
            end
            SEL_B:
            begin
                res_next.rx = m_reg.ax + m_reg.ux[C-1:0];
                res_next.ry = m_reg.ay + m_reg.uy[C-1:0];
            end
            SEL_MID:
            begin
                res_next.rx = m_reg.ax + shx[C-1:0];
                res_next.ry = m_reg.ay + shy[C-1:0];
            end
            default:
            begin
                res_next.rx      = '0;
                res_next.ry      = '0;
                res_next.defined = 1'b0;
            end
        endcase
    end

    // ---------------- Output and skid ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
            skid_valid_reg   <= 1'b0;
        end
        else if (load_out)
        begin
            if (skid_valid_reg)
            begin
                result_valid_reg <= 1'b1;
                skid_valid_reg   <= 1'b0;
            end
            else
            begin
                result_valid_reg <= m_vld_reg;
            end
        end
        else if (en && m_vld_reg)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            result_reg <= skid_valid_reg ? skid_reg : res_next;
        end
        else if (en && m_vld_reg)
        begin
            skid_reg <= res_next;
        end
    end

    // ---------------- Assertions ----------------
    // The skid register only fills behind a result that is being held.
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> result_valid_reg)
        else $error("skid register full while result register empty");

    // A beat leaving the pipeline into a held output must land in the skid.
    a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
        en && m_vld_reg && !load_out |=> skid_valid_reg)
        else $error("beat dropped at the pipeline exit");

    // While frozen, the pipeline keeps its valid bits in place.
    a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(m_vld_reg) && $stable(s4_vld_reg) && $stable(s1_vld_reg))
        else $error("pipeline moved while stalled");

    // The final remainder of an interior item stays below the divisor.
    a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
        dv_vld_reg[FRAC_BITS-1] && dv_reg[FRAC_BITS-1].sel == SEL_MID
        |-> dv_r_reg[FRAC_BITS-1] < dv_q_reg[FRAC_BITS-1])
        else $error("divider remainder not below divisor");

    // An undefined result carries a zero point.
    a_undef_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg && !result_reg.defined
        |-> result_reg.rx == '0 && result_reg.ry == '0)
        else $error("undefined result with nonzero point");

endmodule

`default_nettype wire

>>> test/segment_point_projection_unit_tb.sv
// Testbench for the segment point projection unit: directed cases and random queries.
`timescale 1ns / 1ps

module segment_point_projection_unit_tb;

    import spp_pkg::*;

    localparam int CW          = COORD_BITS;
    localparam int RANDOM_ITEMS = 1200;
    localparam int CYCLE_LIMIT = 300000;
    localparam int DRAIN_CYCLES = FRAC_BITS + 6 + 10;
    localparam int IDLE_PCT    = 11;

    localparam logic MODE_STRICT = 1'b0;
    localparam logic MODE_CLAMP  = 1'b1;

    localparam logic signed [CW-1:0] CMIN = 16'sh8000;
    localparam logic signed [CW-1:0] CMAX = 16'sh7FFF;
    localparam logic signed [CW-1:0] C0   = 16'sd0;

    typedef struct packed {
        query_t  item;
        logic    has_want;
        result_t want;
    } directed_case_t;

    localparam int N_DIRECTED = 18;

    logic    clk = 1'b0;
    logic    rst_n = 1'b0;
    logic    query_valid = 1'b0;
    logic    query_ready;
    query_t  query = '0;
    logic    result_valid;
    logic    result_ready = 1'b0;
    result_t result;

    result_t pending_points[$];
    int      mismatch_count = 0;
    int      cycle_count = 0;
    bit      quiet = 1'b0;

    directed_case_t directed_cases [N_DIRECTED] = '{
        '{'{MODE_STRICT, C0, C0, C0, C0, C0, C0}, 1'b1, '{C0, C0, 1'b1}},
        '{'{MODE_STRICT, 16'sd100, -16'sd200, 16'sd100, -16'sd200, 16'sd7, 16'sd9},
          1'b1, '{16'sd100, -16'sd200, 1'b1}},
        '{'{MODE_STRICT, C0, C0, 16'sd10, C0, -16'sd5, 16'sd3}, 1'b1, '{C0, C0, 1'b0}},
        '{'{MODE_STRICT, C0, C0, 16'sd10, C0, 16'sd20, C0}, 1'b1, '{C0, C0, 1'b0}},
        '{'{MODE_STRICT, C0, C0, 16'sd10, C0, C0, 16'sd7}, 1'b1, '{C0, C0, 1'b1}},
        '{'{MODE_STRICT, C0, C0, 16'sd10, C0, 16'sd10, -16'sd9}, 1'b1, '{16'sd10, C0, 1'b1}},
        '{'{MODE_CLAMP, C0, C0, 16'sd10, C0, -16'sd5, 16'sd3}, 1'b1, '{C0, C0, 1'b1}},
        '{'{MODE_CLAMP, C0, C0, 16'sd10, C0, 16'sd20, C0}, 1'b1, '{16'sd10, C0, 1'b1}},
        '{'{MODE_CLAMP, 16'sd5, 16'sd5, 16'sd5, 16'sd5, 16'sd9, 16'sd9},
          1'b1, '{16'sd5, 16'sd5, 1'b1}},
        '{'{MODE_STRICT, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX}, 1'b1, '{CMAX, CMAX, 1'b1}},
        '{'{MODE_CLAMP, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN}, 1'b1, '{CMIN, CMIN, 1'b1}},
        '{'{MODE_STRICT, CMIN, C0, CMAX, C0, CMAX, CMAX}, 1'b1, '{CMAX, C0, 1'b1}},
        '{'{MODE_STRICT, CMIN, CMIN, CMAX, CMAX, CMAX, CMIN}, 1'b0, '0},
        '{'{MODE_STRICT, CMAX, CMAX, CMIN, CMIN, CMIN, CMAX}, 1'b0, '0},
        '{'{MODE_CLAMP, CMAX, CMIN, CMIN, CMAX, C0, C0}, 1'b0, '0},
        '{'{MODE_CLAMP, CMIN, CMAX, CMAX, CMIN, CMIN, CMIN}, 1'b0, '0},
        '{'{MODE_STRICT, C0, C0, 16'sd3, C0, 16'sd1, 16'sd5}, 1'b0, '0},
        '{'{MODE_STRICT, -16'sd7, 16'sd12, -16'sd300, 16'sd45, -16'sd100, 16'sd90}, 1'b0, '0}
    };

    segment_point_projection_unit uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .query_valid  (query_valid),
        .query_ready  (query_ready),
        .query        (query),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Nearest point on the segment, or the strict projection with its defined flag.
    function automatic result_t project_point(input query_t item);
        longint  ux, uy, wx, wy, dot_uw, len_sq, frac_t;
        result_t r;
        ux     = longint'(item.bx) - longint'(item.ax);
        uy     = longint'(item.by) - longint'(item.ay);
        wx     = longint'(item.px) - longint'(item.ax);
        wy     = longint'(item.py) - longint'(item.ay);
        dot_uw = ux * wx + uy * wy;
        len_sq = ux * ux + uy * uy;
        r.defined = 1'b1;
        if (item.func == MODE_STRICT && (dot_uw < 0 || dot_uw > len_sq))
        begin
            r.rx      = '0;
            r.ry      = '0;
            r.defined = 1'b0;
        end
        else if (dot_uw <= 0)
        begin
            r.rx = item.ax;
            r.ry = item.ay;
        end
        else if (dot_uw >= len_sq)
        begin
            r.rx = item.bx;
            r.ry = item.by;
        end
        else
        begin
            frac_t = (dot_uw <<< FRAC_BITS) / len_sq;
            // Arithmetic shift of a signed product is the floor the offsets need.
            r.rx = CW'(longint'(item.ax) + ((ux * frac_t) >>> FRAC_BITS));
            r.ry = CW'(longint'(item.ay) + ((uy * frac_t) >>> FRAC_BITS));
        end
        return r;
    endfunction

    function automatic logic signed [CW-1:0] clip_coord(input longint v);
        if (v > longint'(CMAX))
            return CMAX;
        if (v < longint'(CMIN))
            return CMIN;
        return CW'(v);
    endfunction

    function automatic logic signed [CW-1:0] small_coord(input int span);
        return CW'(int'($urandom_range(0, 2 * span)) - span);
    endfunction

    // Mixes fully random queries, degenerate segments, small-coordinate queries and points placed near the segment.
    function automatic query_t random_query();
        query_t item;
        int     kind;
        int     k;
        longint ux, uy;
        kind = $urandom_range(0, 9);
        item = query_t'({$urandom, $urandom, $urandom, $urandom});
        item.func = 1'($urandom_range(0, 1));
        if (kind == 2)
        begin
            item.bx = item.ax;
            item.by = item.ay;
        end
        else if (kind >= 3 && kind <= 6)
        begin
            if ($urandom_range(0, 3) != 0)
            begin
                item.bx = clip_coord(longint'(item.ax) + small_coord(2000));
                item.by = clip_coord(longint'(item.ay) + small_coord(2000));
            end
            ux = longint'(item.bx) - longint'(item.ax);
            uy = longint'(item.by) - longint'(item.ay);
            k  = int'($urandom_range(0, 80)) - 8;
            item.px = clip_coord(longint'(item.ax) + (ux * k) / 64 + small_coord(100));
            item.py = clip_coord(longint'(item.ay) + (uy * k) / 64 + small_coord(100));
        end
        else if (kind >= 7)
        begin
            item.ax = small_coord(40);
            item.ay = small_coord(40);
            item.bx = small_coord(40);
            item.by = small_coord(40);
            item.px = small_coord(40);
            item.py = small_coord(40);
        end
        return item;
    endfunction

    task automatic send_query(input query_t item, input result_t want);
        if (!quiet && $urandom_range(0, 99) < IDLE_PCT)
        begin
            query_valid <= 1'b0;
            @(posedge clk);
        end
        query       <= item;
        query_valid <= 1'b1;
        do
            @(posedge clk);
        while (!query_ready);
        pending_points.push_back(want);
    endtask

    task automatic drain_results();
        query_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_points.size() != 0);
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
            result_ready <= quiet || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && result_valid && result_ready)
        begin
            if (pending_points.size() == 0)
            begin
                $error("result beat with nothing expected: rx %0d ry %0d defined %0b",
                       result.rx, result.ry, result.defined);
                mismatch_count++;
            end
            else
            begin
                want = pending_points.pop_front();
                if (result.rx !== want.rx)
                begin
                    $error("rx mismatch: expected %0d, actual %0d", want.rx, result.rx);
                    mismatch_count++;
                end
                if (result.ry !== want.ry)
                begin
                    $error("ry mismatch: expected %0d, actual %0d", want.ry, result.ry);
                    mismatch_count++;
                end
                if (result.defined !== want.defined)
                begin
                    $error("defined mismatch: expected %0b, actual %0b",
                           want.defined, result.defined);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin
        query_t item;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_cases[i])
        begin
            item = directed_cases[i].item;
            send_query(item, directed_cases[i].has_want ? directed_cases[i].want
                                                        : project_point(item));
        end
        drain_results();

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            quiet = (n >= 500 && n < 700);
            if (n == 850)
                drain_results();
            item = random_query();
            send_query(item, project_point(item));
        end
        quiet = 1'b0;

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
